// ----- hdl/rbq_pkg.sv -----
// Shared types and constants for the reset button qualifier.
package rbq_pkg;

    // Field and register widths.
    localparam int unsigned TIME_W    = 63;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned MIN_W     = 5;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 63;

    // Auto-press deadline arithmetic.
    localparam int unsigned SECONDS_PER_MINUTE = 60;
    localparam int unsigned SEC_W  = 11;
    localparam int unsigned PROD_W = SEC_W + TICK_W;
    localparam int unsigned FIRE_W = TIME_W + 1;

    // Divider sizing: one quotient bit per step.
    localparam int unsigned DIV_STEPS = TIME_W;
    localparam int unsigned DIV_CNT_W = 6;

    // Request kinds carried on tuser.
    localparam logic REQ_POLL      = 1'b0;
    localparam logic REQ_INTERRUPT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_QUALIFY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SEC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_MINUTES  = 3'd4;

    // Configuration reset values.
    localparam logic [TICK_W-1:0] PRESS_QUALIFY_RST = 32'd4050;
    localparam logic [TICK_W-1:0] RELEASE_HOLD_RST  = 32'd1620000;
    localparam logic [TICK_W-1:0] TICKS_PER_SEC_RST = 32'd40500000;

    // One accepted request as seen by the qualifier.
    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] now;
        logic              button_released;
    } rbq_item_t;

    // Divider start request.
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [TICK_W-1:0] divisor;
    } rbq_div_req_t;

    // Divider status and result.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TIME_W-1:0] quotient;
    } rbq_div_rsp_t;

endpackage

// ----- hdl/reset_button_qualifier.sv -----
// Reset button qualifier top level: configuration, sequencer and result register.
//
// Each request returns one result. An interrupt, or a poll with auto-press
// disabled, goes from acceptance straight to the finish state and from there
// into the result register. A poll with auto-press enabled passes through the
// multiply, add and compare states before the finish state when its deadline
// has not passed, and also through the divide state when it has, where the
// 63-step bit-serial divider divides the elapsed time by the tick rate.
// The block takes no new request until the current one has been placed in the
// result register; the result register itself lets a new request in while an
// earlier result waits, and a finished request waits for that earlier result
// to be taken.
module reset_button_qualifier (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel. tdata: now [62:0], button_released [63].
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,
    // tuser: req_type (0 poll, 1 interrupt).
    input  logic                              s_tuser,
    // Result channel. tdata: button_state [0], zero fill [7:1].
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [rbq_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [rbq_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
    import rbq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_CMP,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [TICK_W-1:0] press_qualify_reg;
    logic [TICK_W-1:0] release_hold_reg;
    logic [TICK_W-1:0] ticks_per_sec_reg;
    logic [TIME_W-1:0] start_time_reg;
    logic [MIN_W-1:0]  auto_minutes_reg;

    logic [TIME_W-1:0] now_reg;
    logic              st_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [FIRE_W-1:0] fire_reg;
    logic              m_tvalid_reg;
    logic              out_state_reg;

    rbq_item_t    item;
    rbq_div_req_t div_req;
    rbq_div_rsp_t div_rsp;
    logic         s_accept;
    logic         qual_state;
    logic [TICK_W-1:0] tick_rate;
    logic [SEC_W-1:0]  fire_seconds;
    logic [FIRE_W:0]   elapsed;
    logic              deadline_passed;
    logic              result_load;

    assign item.req_type        = s_tuser;
    assign item.now             = s_tdata[TIME_W-1:0];
    assign item.button_released = s_tdata[TIME_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // A zero tick rate counts as one.
    assign tick_rate    = (ticks_per_sec_reg == '0) ? TICK_W'(1) : ticks_per_sec_reg;
    assign fire_seconds = SEC_W'(auto_minutes_reg) * SEC_W'(SECONDS_PER_MINUTE);

    // Time past the deadline; it fires only when strictly positive.
    assign elapsed         = {2'b00, now_reg} - {1'b0, fire_reg};
    assign deadline_passed = !elapsed[FIRE_W] && (elapsed != '0);

    assign div_req.start    = (state_reg == ST_CMP) && deadline_passed;
    assign div_req.dividend = elapsed[TIME_W-1:0];
    assign div_req.divisor  = tick_rate;

    // The finished answer moves into the result register once it is free.
    assign result_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    rbq_qualifier u_qualifier (
        .clk                 (clk),
        .rst_n               (rst_n),
        .accept              (s_accept),
        .item                (item),
        .press_qualify_ticks (press_qualify_reg),
        .release_hold_ticks  (release_hold_reg),
        .qual_state          (qual_state)
    );

    rbq_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_qualify_reg <= PRESS_QUALIFY_RST;
            release_hold_reg  <= RELEASE_HOLD_RST;
            ticks_per_sec_reg <= TICKS_PER_SEC_RST;
            start_time_reg    <= '0;
            auto_minutes_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PRESS_QUALIFY: press_qualify_reg <= cfg_wdata[TICK_W-1:0];
                REG_RELEASE_HOLD:  release_hold_reg  <= cfg_wdata[TICK_W-1:0];
                REG_TICKS_PER_SEC: ticks_per_sec_reg <= cfg_wdata[TICK_W-1:0];
                REG_START_TIME:    start_time_reg    <= cfg_wdata[TIME_W-1:0];
                REG_AUTO_MINUTES:  auto_minutes_reg  <= cfg_wdata[MIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            out_state_reg <= 1'b0;
            now_reg       <= '0;
            st_reg        <= 1'b0;
            prod_reg      <= '0;
            fire_reg      <= '0;
        end
        else
        begin
            // Load a finished answer, or clear the result once it is taken.
            if (result_load)
            begin
                m_tvalid_reg  <= 1'b1;
                out_state_reg <= st_reg;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        now_reg <= item.now;
                        st_reg  <= qual_state;
                        if ((item.req_type == REQ_POLL) && (auto_minutes_reg != '0))
                        begin
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= PROD_W'(fire_seconds) * PROD_W'(tick_rate);
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    fire_reg  <= {1'b0, start_time_reg} + FIRE_W'(prod_reg);
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    state_reg <= deadline_passed ? ST_DIV : ST_FINISH;
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        st_reg    <= ~div_rsp.quotient[1];
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (result_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_state_reg};

    // The divider is only started when it is free.
    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Interrupt requests go straight to the result stage.
    a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (s_tuser == REQ_INTERRUPT)) |=> (state_reg == ST_FINISH))
        else $error("interrupt request did not go to the result stage");

    // A result only completes while the divider is not working.
    a_divider_idle_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> !div_rsp.busy)
        else $error("result stage reached with divider still running");

    // The divider result is taken only while waiting for it.
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide wait");

endmodule

// ----- hdl/rbq_divider.sv -----
// Restoring divider that produces one quotient bit per cycle.
module rbq_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rbq_pkg::rbq_div_req_t div_req,
    output rbq_pkg::rbq_div_rsp_t div_rsp
);
    import rbq_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TICK_W-1:0]    rem_reg;
    logic [TIME_W-1:0]    dvd_reg;
    logic [TICK_W-1:0]    dvs_reg;
    logic [TICK_W:0]      trial;
    logic [TICK_W+1:0]    diff;
    logic                 qbit;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {rem_reg, dvd_reg[TIME_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign qbit  = ~diff[TICK_W+1];

    // Step control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvd_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            // Done pulses for one cycle after the last step.
            done_reg <= !div_req.start && busy_reg && (cnt_reg == '0);
            if (div_req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
                rem_reg  <= '0;
                dvd_reg  <= div_req.dividend;
                dvs_reg  <= div_req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= qbit ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
                dvd_reg <= {dvd_reg[TIME_W-2:0], qbit};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign div_rsp.busy     = busy_reg;
    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = dvd_reg;

endmodule

// ----- hdl/rbq_qualifier.sv -----
// Button press qualification state and the per-request qualified answer.
module rbq_qualifier (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  rbq_pkg::rbq_item_t          item,
    input  logic [rbq_pkg::TICK_W-1:0]  press_qualify_ticks,
    input  logic [rbq_pkg::TICK_W-1:0]  release_hold_ticks,
    output logic                        qual_state
);
    import rbq_pkg::*;

    logic              is_down_reg;
    logic              last_reported_reg;
    logic [TIME_W-1:0] release_time_reg;
    logic [TIME_W-1:0] press_time_reg;

    logic              hold_running;
    logic signed [TIME_W:0] since_press;
    logic signed [TIME_W:0] since_release;
    logic              qualified_long;
    logic              within_hold;

    // Signed time differences, so time running backwards is handled.
    assign hold_running  = (release_time_reg != '0);
    assign since_press   = $signed({1'b0, item.now}) - $signed({1'b0, press_time_reg});
    assign since_release = $signed({1'b0, item.now}) - $signed({1'b0, release_time_reg});
    assign qualified_long = $signed({{(TIME_W+1-TICK_W){1'b0}}, press_qualify_ticks})
                            < since_press;
    assign within_hold    = since_release
                            < $signed({{(TIME_W+1-TICK_W){1'b0}}, release_hold_ticks});

    // Answer for this request before any auto-press override.
    always_comb
    begin
        if (item.req_type == REQ_INTERRUPT)
        begin
            qual_state = ~item.button_released;
        end
        else if (!item.button_released)
        begin
            qual_state = is_down_reg ? (hold_running || qualified_long) : hold_running;
        end
        else if (is_down_reg)
        begin
            qual_state = last_reported_reg;
        end
        else
        begin
            qual_state = hold_running && within_hold;
        end
    end

    // State update on each accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_down_reg       <= 1'b0;
            last_reported_reg <= 1'b0;
            release_time_reg  <= '0;
            press_time_reg    <= '0;
        end
        else if (accept)
        begin
            if (item.req_type == REQ_INTERRUPT)
            begin
                press_time_reg <= item.now;
                if (!item.button_released)
                begin
                    is_down_reg       <= 1'b1;
                    last_reported_reg <= 1'b1;
                end
            end
            else
            begin
                last_reported_reg <= qual_state;
                if (!item.button_released)
                begin
                    if (!is_down_reg)
                    begin
                        is_down_reg    <= 1'b1;
                        press_time_reg <= item.now;
                    end
                end
                else if (is_down_reg)
                begin
                    is_down_reg      <= 1'b0;
                    release_time_reg <= qual_state ? item.now : '0;
                end
                else if (!qual_state)
                begin
                    release_time_reg <= '0;
                end
            end
        end
    end

endmodule
